@@ hdl/hss_pkg.sv @@
// Shared types, constants and register codes of the heat stencil sweep.
package hss_pkg;

    localparam int MAX_WIDTH  = 1024;
    localparam int COL_BITS   = $clog2(MAX_WIDTH);
    localparam int ROW_BITS   = 16;
    localparam int PW_BITS    = 11;
    localparam int TEMP_BITS  = 32;
    localparam int GAIN_BITS  = 17;
    localparam int SUM_BITS   = TEMP_BITS + 2;
    localparam int DIFF_BITS  = TEMP_BITS + 4;
    localparam int FRAC_SHIFT = 19;
    localparam int DH_BITS    = DIFF_BITS - FRAC_SHIFT;
    localparam int PHI_BITS   = GAIN_BITS + 1 + DH_BITS;
    localparam int PLO_BITS   = GAIN_BITS + FRAC_SHIFT + 1;

    localparam logic [GAIN_BITS-1:0] GAIN_ONE   = GAIN_BITS'(65536);
    localparam logic [GAIN_BITS-1:0] GAIN_RESET = GAIN_BITS'(32768);
    localparam logic [PLO_BITS-1:0]  ROUND_HALF = PLO_BITS'(1) << (FRAC_SHIFT - 1);

    // Configuration register indexes.
    localparam logic [1:0] CFG_WIDTH  = 2'd0;
    localparam logic [1:0] CFG_HEIGHT = 2'd1;
    localparam logic [1:0] CFG_GAIN   = 2'd2;

    typedef struct packed {
        logic                        fixed;
        logic signed [TEMP_BITS-1:0] temp;
    } entry_t;

    typedef struct packed {
        entry_t top;
        entry_t mid;
        entry_t bot;
    } column_t;

    typedef struct packed {
        logic signed [SUM_BITS-1:0]  sum_near;
        logic signed [SUM_BITS-1:0]  sum_far;
        logic signed [SUM_BITS-1:0]  sum_new;
        logic signed [TEMP_BITS-1:0] old;
        logic                        fixed;
        logic                        last;
    } blend_in_t;

endpackage

@@ hdl/hss_line_store.sv @@
// One line of grid entries: single write port, registered read port.
module hss_line_store (
    input  logic                          clk,
    input  logic                          we,
    input  logic [hss_pkg::COL_BITS-1:0]  waddr,
    input  hss_pkg::entry_t               wdata,
    input  logic                          re,
    input  logic [hss_pkg::COL_BITS-1:0]  raddr,
    output hss_pkg::entry_t               rdata
);
    import hss_pkg::*;

    entry_t mem [MAX_WIDTH];
    entry_t rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

@@ hdl/hss_cell.sv @@
// One column of the stencil window; takes the column on its right on each shift.
module hss_cell (
    input  logic             clk,
    input  logic             shift,
    input  hss_pkg::column_t col_in,
    output hss_pkg::column_t col_out
);
    import hss_pkg::*;

    column_t col_reg;

    always_ff @(posedge clk)
    begin
        if (shift)
        begin
            col_reg <= col_in;
        end
    end

    assign col_out = col_reg;

endmodule

@@ hdl/hss_blend.sv @@
// Blend pipeline: difference, split multiply by the gain, rounding and output register.
module hss_blend (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                in_valid,
    output logic                                in_ready,
    input  hss_pkg::blend_in_t                  in_data,
    input  logic [hss_pkg::GAIN_BITS-1:0]       gain,
    output logic                                out_valid,
    input  logic                                out_ready,
    output logic signed [hss_pkg::TEMP_BITS-1:0] out_temp,
    output logic                                out_last
);
    import hss_pkg::*;

    logic v2_reg, v3_reg, v4_reg, v5_reg;
    logic ready2, ready3, ready4, ready5;

    blend_in_t s2_reg;

    logic signed [DIFF_BITS-1:0] d3_reg;
    logic signed [TEMP_BITS-1:0] old3_reg;
    logic                        fixed3_reg;
    logic                        last3_reg;

    logic signed [PHI_BITS-1:0]  phi4_reg;
    logic [PLO_BITS-1:0]         plo4_reg;
    logic signed [TEMP_BITS-1:0] old4_reg;
    logic                        fixed4_reg;
    logic                        last4_reg;

    logic signed [TEMP_BITS-1:0] temp5_reg;
    logic                        last5_reg;

    logic signed [DIFF_BITS-1:0] d_c;
    logic signed [DH_BITS-1:0]   dh_c;
    logic [FRAC_SHIFT-1:0]       dl_c;
    logic signed [PHI_BITS-1:0]  phi_c;
    logic [PLO_BITS-1:0]         plo_c;
    logic signed [DIFF_BITS-1:0] res_c;
    logic signed [TEMP_BITS-1:0] temp_c;

    // A stage loads when it is empty or the stage after it moves on.
    assign ready5   = !v5_reg || out_ready;
    assign ready4   = !v4_reg || ready5;
    assign ready3   = !v3_reg || ready4;
    assign ready2   = !v2_reg || ready3;
    assign in_ready = ready2;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            v4_reg <= 1'b0;
            v5_reg <= 1'b0;
        end
        else
        begin
            if (ready2)
            begin
                v2_reg <= in_valid;
            end
            if (ready3)
            begin
                v3_reg <= v2_reg;
            end
            if (ready4)
            begin
                v4_reg <= v3_reg;
            end
            if (ready5)
            begin
                v5_reg <= v4_reg;
            end
        end
    end

    // d = sum of the eight neighbors minus eight times the center.
    assign d_c = DIFF_BITS'(s2_reg.sum_near) + DIFF_BITS'(s2_reg.sum_far)
               + DIFF_BITS'(s2_reg.sum_new) - (DIFF_BITS'(s2_reg.old) <<< 3);

    // k*d is split at bit 19 so that both products stay narrow.
    assign dh_c  = d3_reg[DIFF_BITS-1:FRAC_SHIFT];
    assign dl_c  = d3_reg[FRAC_SHIFT-1:0];
    assign phi_c = PHI_BITS'($signed({1'b0, gain})) * PHI_BITS'(dh_c);
    assign plo_c = PLO_BITS'(gain) * PLO_BITS'(dl_c) + ROUND_HALF;

    assign res_c = DIFF_BITS'(old4_reg) + DIFF_BITS'(phi4_reg)
                 + DIFF_BITS'(plo4_reg[PLO_BITS-1:FRAC_SHIFT]);
    assign temp_c = fixed4_reg ? old4_reg : res_c[TEMP_BITS-1:0];

    always_ff @(posedge clk)
    begin
        if (ready2 && in_valid)
        begin
            s2_reg <= in_data;
        end
        if (ready3 && v2_reg)
        begin
            d3_reg     <= d_c;
            old3_reg   <= s2_reg.old;
            fixed3_reg <= s2_reg.fixed;
            last3_reg  <= s2_reg.last;
        end
        if (ready4 && v3_reg)
        begin
            phi4_reg   <= phi_c;
            plo4_reg   <= plo_c;
            old4_reg   <= old3_reg;
            fixed4_reg <= fixed3_reg;
            last4_reg  <= last3_reg;
        end
        if (ready5 && v4_reg)
        begin
            temp5_reg <= temp_c;
            last5_reg <= last4_reg;
        end
    end

    assign out_valid = v5_reg;
    assign out_temp  = temp5_reg;
    assign out_last  = last5_reg;

    a_stall_means_full: assert property (@(posedge clk) disable iff (!rst_n)
        !in_ready |-> (v2_reg && v3_reg && v4_reg && v5_reg))
        else $error("blend pipeline stalled with an empty stage");

    a_heater_holds: assert property (@(posedge clk) disable iff (!rst_n)
        (v4_reg && ready5 && fixed4_reg) |=> (temp5_reg == $past(old4_reg)))
        else $error("heater cell did not keep its temperature");

endmodule

@@ hdl/heat_stencil_sweep.sv @@
// Top level: position counters, line stores, window cells and blend pipeline.
//
//  Channel   Direction  Payload
//  s_*       in         tdata[31:0] cell_temp, tuser is_fixed
//  m_*       out        tdata[31:0] new_temp, tlast last_cell
//  cfg_*     in         index 0 padded_width, 1 padded_height, 2 blend_gain
//
// One cell is taken per cycle unless the blend stalls; line stores and window keep pace.
// Once its lower-right neighbor is taken, a result passes s1, s2, d3, phi4 and temp5.
// Reset clears the counters and the handshake state; no clearing pass is run.
// A stalled output fills the blend stages first; input stalls only once they are full.
module heat_stencil_sweep (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                s_tvalid,
    output logic                                s_tready,
    input  logic signed [hss_pkg::TEMP_BITS-1:0] s_tdata,  // [31:0] cell_temp
    input  logic                                s_tuser,  // [0] is_fixed
    output logic                                m_tvalid,
    input  logic                                m_tready,
    output logic signed [hss_pkg::TEMP_BITS-1:0] m_tdata,  // [31:0] new_temp
    output logic                                m_tlast,
    input  logic                                cfg_we,
    input  logic [1:0]                          cfg_index,
    input  logic [hss_pkg::GAIN_BITS-1:0]       cfg_wdata
);
    import hss_pkg::*;

    logic [COL_BITS-1:0]  col_reg,   col_next;
    logic [ROW_BITS-1:0]  row_reg,   row_next;
    logic [COL_BITS-1:0]  wlast_reg, wlast_next;
    logic [ROW_BITS-1:0]  hlast_reg, hlast_next;
    logic [GAIN_BITS-1:0] gain_reg,  gain_next;

    logic [PW_BITS-1:0]   pw_c;
    logic [ROW_BITS-1:0]  ph_c;
    logic [COL_BITS-1:0]  c_cur;
    logic                 accept;

    logic                 s1_valid_reg;
    logic [COL_BITS-1:0]  s1_col_reg;
    entry_t               s1_bot_reg;
    logic                 s1_prod_reg;
    logic                 s1_last_reg;
    logic                 s1_fire;

    entry_t               bot_in;
    entry_t               upper_rd;
    entry_t               lower_rd;
    column_t              col_new;
    column_t              cell_a;
    column_t              cell_b;

    blend_in_t            blend_in;
    logic                 blend_ready;

    assign accept = s_tvalid && s_tready;
    assign c_cur  = (col_reg > wlast_reg) ? wlast_reg : col_reg;
    assign pw_c   = cfg_wdata[PW_BITS-1:0];
    assign ph_c   = cfg_wdata[ROW_BITS-1:0];

    always_comb
    begin
        col_next   = col_reg;
        row_next   = row_reg;
        wlast_next = wlast_reg;
        hlast_next = hlast_reg;
        gain_next  = gain_reg;
        if (cfg_we && (cfg_index == CFG_WIDTH))
        begin
            if (pw_c < PW_BITS'(3))
            begin
                wlast_next = COL_BITS'(2);
            end
            else if (pw_c > PW_BITS'(MAX_WIDTH))
            begin
                wlast_next = COL_BITS'(MAX_WIDTH - 1);
            end
            else
            begin
                wlast_next = COL_BITS'(pw_c - PW_BITS'(1));
            end
            col_next = '0;
            row_next = '0;
        end
        else if (cfg_we && (cfg_index == CFG_HEIGHT))
        begin
            hlast_next = (ph_c < ROW_BITS'(3)) ? ROW_BITS'(2) : ph_c - ROW_BITS'(1);
            col_next   = '0;
            row_next   = '0;
        end
        else if (cfg_we && (cfg_index == CFG_GAIN))
        begin
            gain_next = (cfg_wdata > GAIN_ONE) ? GAIN_ONE : cfg_wdata;
        end
        else if (accept)
        begin
            if (c_cur >= wlast_reg)
            begin
                col_next = '0;
                row_next = (row_reg >= hlast_reg) ? '0 : row_reg + ROW_BITS'(1);
            end
            else
            begin
                col_next = c_cur + COL_BITS'(1);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            col_reg   <= '0;
            row_reg   <= '0;
            wlast_reg <= COL_BITS'(2);
            hlast_reg <= ROW_BITS'(2);
            gain_reg  <= GAIN_RESET;
        end
        else
        begin
            col_reg   <= col_next;
            row_reg   <= row_next;
            wlast_reg <= wlast_next;
            hlast_reg <= hlast_next;
            gain_reg  <= gain_next;
        end
    end

    // Stage 1 holds the arriving cell while both line stores are read.
    assign s1_fire  = s1_valid_reg && (!s1_prod_reg || blend_ready);
    assign s_tready = !s1_valid_reg || s1_fire;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else if (accept)
        begin
            s1_valid_reg <= 1'b1;
        end
        else if (s1_fire)
        begin
            s1_valid_reg <= 1'b0;
        end
    end

    assign bot_in.fixed = s_tuser;
    assign bot_in.temp  = s_tdata;

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s1_col_reg  <= c_cur;
            s1_bot_reg  <= bot_in;
            s1_prod_reg <= (row_reg >= ROW_BITS'(2)) && (c_cur >= COL_BITS'(2));
            s1_last_reg <= (row_reg >= hlast_reg) && (c_cur >= wlast_reg);
        end
    end

    // The lower line takes the new cell; its old entry moves up one row in the cycle after.
    hss_line_store u_lower (
        .clk   (clk),
        .we    (accept),
        .waddr (c_cur),
        .wdata (bot_in),
        .re    (accept),
        .raddr (c_cur),
        .rdata (lower_rd)
    );

    hss_line_store u_upper (
        .clk   (clk),
        .we    (s1_valid_reg),
        .waddr (s1_col_reg),
        .wdata (lower_rd),
        .re    (accept),
        .raddr (c_cur),
        .rdata (upper_rd)
    );

    assign col_new.top = upper_rd;
    assign col_new.mid = lower_rd;
    assign col_new.bot = s1_bot_reg;

    hss_cell u_cell_a (
        .clk     (clk),
        .shift   (s1_fire),
        .col_in  (col_new),
        .col_out (cell_a)
    );

    hss_cell u_cell_b (
        .clk     (clk),
        .shift   (s1_fire),
        .col_in  (cell_a),
        .col_out (cell_b)
    );

    // The center of the window is the middle entry of the first cell.
    assign blend_in.sum_near = SUM_BITS'(cell_a.top.temp) + SUM_BITS'(cell_a.bot.temp);
    assign blend_in.sum_far  = SUM_BITS'(cell_b.top.temp) + SUM_BITS'(cell_b.mid.temp)
                             + SUM_BITS'(cell_b.bot.temp);
    assign blend_in.sum_new  = SUM_BITS'(col_new.top.temp) + SUM_BITS'(col_new.mid.temp)
                             + SUM_BITS'(col_new.bot.temp);
    assign blend_in.old      = cell_a.mid.temp;
    assign blend_in.fixed    = cell_a.mid.fixed;
    assign blend_in.last     = s1_last_reg;

    hss_blend u_blend (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (s1_valid_reg && s1_prod_reg),
        .in_ready  (blend_ready),
        .in_data   (blend_in),
        .gain      (gain_reg),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .out_temp  (m_tdata),
        .out_last  (m_tlast)
    );

    a_no_line_collision: assert property (@(posedge clk) disable iff (!rst_n)
        (s1_valid_reg && accept) |-> (s1_col_reg != c_cur))
        else $error("upper line write and read hit the same column");

    a_column_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        accept |-> (col_reg <= wlast_reg))
        else $error("column counter beyond the grid width");

    a_input_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
        !s_tready |-> (s1_valid_reg && s1_prod_reg && !blend_ready))
        else $error("input stalled without a blocked result");

endmodule

@@ tb/heat_stencil_sweep_tb.sv @@
// Self-checking testbench for the heat stencil sweep: random grids, stalls and register sweeps.
module heat_stencil_sweep_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import hss_pkg::*;

    localparam int SETTLE_CYCLES  = 16;
    localparam int HOLD_CYCLES    = 300;
    localparam int WATCHDOG_LIMIT = 4000;
    localparam int RANDOM_ITEMS   = 300;
    localparam int STEADY_ITEMS   = 200;

    localparam logic [1:0] CFG_UNUSED = 2'd3;

    localparam logic signed [TEMP_BITS-1:0] TEMP_MAX = {1'b0, {(TEMP_BITS-1){1'b1}}};
    localparam logic signed [TEMP_BITS-1:0] TEMP_MIN = {1'b1, {(TEMP_BITS-1){1'b0}}};
    localparam longint ROUND_BIAS = longint'(1) << 18;

    typedef struct packed {
        logic signed [TEMP_BITS-1:0] temp;
        logic                        last;
    } update_t;

    logic                        clk = 1'b0;
    logic                        rst_n;
    logic                        s_tvalid;
    logic                        s_tready;
    logic signed [TEMP_BITS-1:0] s_tdata;
    logic                        s_tuser;
    logic                        m_tvalid;
    logic                        m_tready;
    logic signed [TEMP_BITS-1:0] m_tdata;
    logic                        m_tlast;
    logic                        cfg_we;
    logic [1:0]                  cfg_index;
    logic [GAIN_BITS-1:0]        cfg_wdata;

    // Mirror of the block: line stores, 3x2 window, position and registers.
    entry_t               upper_row [MAX_WIDTH];
    entry_t               lower_row [MAX_WIDTH];
    entry_t               window_cells [6];
    int unsigned          col_pos;
    int unsigned          row_pos;
    logic [PW_BITS-1:0]   grid_width;
    logic [ROW_BITS-1:0]  grid_height;
    logic [GAIN_BITS-1:0] gain_k;

    update_t queued_updates[$];
    int      mismatch_count;
    int      quiet_cycles;
    bit      src_gaps_on;
    bit      sink_stalls_on;
    bit      hold_request;

    heat_stencil_sweep uut (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tlast   (m_tlast),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata)
    );

    initial
    begin
        forever #5 clk = ~clk;
    end

    function automatic int eff_width();
        if (grid_width < 3)
            return 3;
        if (grid_width > MAX_WIDTH)
            return MAX_WIDTH;
        return int'(grid_width);
    endfunction

    function automatic int eff_height();
        if (grid_height < 3)
            return 3;
        return int'(grid_height);
    endfunction

    // Shifts one cell into the mirror and queues the interior update it completes.
    function automatic void diffuse_cell(logic signed [TEMP_BITS-1:0] temp, logic fixed);
        int unsigned w;
        int unsigned h;
        int unsigned k;
        int unsigned c;
        int unsigned r;
        entry_t      top;
        entry_t      mid;
        entry_t      bot;
        longint      old;
        longint      nsum;
        longint      diff;
        longint      res;
        update_t     item;
        w = eff_width();
        h = eff_height();
        k = int'((gain_k > GAIN_ONE) ? GAIN_ONE : gain_k);
        c = (col_pos >= w) ? w - 1 : col_pos;
        r = row_pos;
        bot.fixed = fixed;
        bot.temp = temp;
        top = upper_row[c];
        mid = lower_row[c];
        upper_row[c] = mid;
        lower_row[c] = bot;
        if (r >= 2 && c >= 2)
        begin
            old = longint'(window_cells[1].temp);
            if (window_cells[1].fixed)
                res = old;
            else
            begin
                nsum = longint'(window_cells[0].temp) + longint'(window_cells[2].temp)
                     + longint'(window_cells[3].temp) + longint'(window_cells[4].temp)
                     + longint'(window_cells[5].temp) + longint'(top.temp)
                     + longint'(mid.temp) + longint'(bot.temp);
                diff = nsum - 8 * old;
                // Round to nearest with ties going up; the shift floors negatives.
                res = old + ((longint'(k) * diff + ROUND_BIAS) >>> 19);
            end
            item.temp = res[TEMP_BITS-1:0];
            item.last = (r >= h - 1) && (c >= w - 1);
            queued_updates.push_back(item);
        end
        window_cells[3] = window_cells[0];
        window_cells[4] = window_cells[1];
        window_cells[5] = window_cells[2];
        window_cells[0] = top;
        window_cells[1] = mid;
        window_cells[2] = bot;
        if (c >= w - 1)
        begin
            col_pos = 0;
            row_pos = (r >= h - 1) ? 0 : r + 1;
        end
        else
        begin
            col_pos = c + 1;
            row_pos = r;
        end
    endfunction

    function automatic void apply_reg(logic [1:0] idx, logic [GAIN_BITS-1:0] value);
        case (idx)
            CFG_WIDTH:
            begin
                grid_width = value[PW_BITS-1:0];
                col_pos = 0;
                row_pos = 0;
            end
            CFG_HEIGHT:
            begin
                grid_height = value[ROW_BITS-1:0];
                col_pos = 0;
                row_pos = 0;
            end
            CFG_GAIN:
                gain_k = value;
            default:
                ;
        endcase
    endfunction

    function automatic logic signed [TEMP_BITS-1:0] random_temp();
        case ($urandom_range(0, 9))
            0:       return TEMP_MAX;
            1:       return TEMP_MIN;
            2:       return TEMP_BITS'($urandom_range(0, 8)) - TEMP_BITS'(4);
            3, 4:    return $urandom();
            default: return TEMP_BITS'($urandom_range(0, 200 << 16)) - TEMP_BITS'(100 << 16);
        endcase
    endfunction

    function automatic logic [GAIN_BITS-1:0] random_gain();
        case ($urandom_range(0, 7))
            0:       return '0;
            1:       return GAIN_ONE;
            2:       return GAIN_BITS'($urandom_range(65537, 131071));
            default: return GAIN_BITS'($urandom_range(0, 65536));
        endcase
    endfunction

    task automatic send_cell(input logic signed [TEMP_BITS-1:0] temp, input logic fixed);
        if (src_gaps_on && $urandom_range(0, 7) == 0)
        begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 10)) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= temp;
        s_tuser  <= fixed;
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        diffuse_cell(temp, fixed);
    endtask

    task automatic send_cells(input int count);
        for (int i = 0; i < count; i++)
            send_cell(random_temp(), $urandom_range(0, 7) == 0);
    endtask

    // Registers change only once every queued update is out and the pipeline has drained.
    task automatic write_reg(input logic [1:0] idx, input logic [GAIN_BITS-1:0] value);
        s_tvalid <= 1'b0;
        while (queued_updates.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= value;
        @(posedge clk);
        apply_reg(idx, value);
        cfg_we <= 1'b0;
    endtask

    // Reset geometry and gain: a hot ring around the coldest possible center.
    task automatic test_default_frame();
        for (int i = 0; i < 9; i++)
            send_cell((i == 4) ? TEMP_MIN : TEMP_MAX, 1'b0);
    endtask

    // Full gain with half-step sums on both signs, and a heater between them.
    task automatic test_rounding_and_heater();
        logic signed [TEMP_BITS-1:0] t;
        write_reg(CFG_GAIN, '1);
        write_reg(CFG_WIDTH, GAIN_BITS'(5));
        for (int i = 0; i < 15; i++)
        begin
            t = '0;
            if (i == 1)
                t = TEMP_BITS'(4);
            if (i == 3)
                t = -TEMP_BITS'(4);
            send_cell(t, i == 7 || i == 10);
        end
    endtask

    task automatic test_geometry_clamps();
        write_reg(CFG_WIDTH, '0);
        write_reg(CFG_HEIGHT, '0);
        write_reg(CFG_GAIN, '0);
        send_cells(9);
        // Only the low bits of the write data reach the width register.
        write_reg(CFG_WIDTH, GAIN_BITS'('h1F803));
        write_reg(CFG_HEIGHT, GAIN_BITS'(2));
        write_reg(CFG_UNUSED, '1);
        write_reg(CFG_GAIN, GAIN_RESET);
        send_cells(18);
        // A geometry write in the middle of a grid starts a fresh one.
        write_reg(CFG_WIDTH, GAIN_BITS'(6));
        write_reg(CFG_HEIGHT, GAIN_BITS'(5));
        send_cells(17);
        write_reg(CFG_HEIGHT, GAIN_BITS'(4));
        send_cells(24);
    endtask

    task automatic test_widest_rows();
        write_reg(CFG_WIDTH, GAIN_BITS'(256));
        write_reg(CFG_HEIGHT, GAIN_BITS'(1));
        write_reg(CFG_GAIN, random_gain());
        send_cells(eff_width() * eff_height());
    endtask

    task automatic test_tallest_grid();
        write_reg(CFG_WIDTH, GAIN_BITS'(3));
        write_reg(CFG_HEIGHT, GAIN_BITS'('hFFFF));
        write_reg(CFG_GAIN, GAIN_ONE);
        send_cells(45);
    endtask

    // The sink holds off while the source keeps offering, so the input must stall.
    task automatic test_output_holdoff();
        write_reg(CFG_WIDTH, GAIN_BITS'(8));
        write_reg(CFG_HEIGHT, GAIN_BITS'(6));
        write_reg(CFG_GAIN, random_gain());
        src_gaps_on = 1'b0;
        hold_request = 1'b1;
        send_cells(3 * 8 * 6);
        src_gaps_on = 1'b1;
    endtask

    task automatic test_random_grids();
        int sent;
        int w_raw;
        int h_raw;
        int cells;
        sent = 0;
        while (sent < RANDOM_ITEMS)
        begin
            src_gaps_on = ($urandom_range(0, 4) != 0);
            sink_stalls_on = ($urandom_range(0, 4) != 0);
            case ($urandom_range(0, 9))
                0:       w_raw = $urandom_range(0, 2);
                1, 2:    w_raw = $urandom_range(13, 40);
                default: w_raw = $urandom_range(3, 12);
            endcase
            h_raw = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 2) : $urandom_range(3, 7);
            write_reg(CFG_WIDTH, {6'($urandom), 11'(w_raw)});
            write_reg(CFG_HEIGHT, {1'($urandom), 16'(h_raw)});
            write_reg(CFG_GAIN, random_gain());
            cells = $urandom_range(1, 3) * eff_width() * eff_height();
            // Now and then a grid is cut short; the next geometry write restarts it.
            if ($urandom_range(0, 5) == 0)
                cells += $urandom_range(1, eff_width() * eff_height() - 1);
            if (cells > RANDOM_ITEMS - sent)
                cells = RANDOM_ITEMS - sent;
            send_cells(cells);
            sent += cells;
        end
        src_gaps_on = 1'b1;
        sink_stalls_on = 1'b1;
    endtask

    task automatic test_steady_stream();
        int sent;
        int cells;
        sent = 0;
        src_gaps_on = 1'b0;
        sink_stalls_on = 1'b0;
        while (sent < STEADY_ITEMS)
        begin
            write_reg(CFG_WIDTH, GAIN_BITS'($urandom_range(3, 20)));
            write_reg(CFG_HEIGHT, GAIN_BITS'($urandom_range(3, 6)));
            write_reg(CFG_GAIN, random_gain());
            cells = 2 * eff_width() * eff_height();
            if (cells > STEADY_ITEMS - sent)
                cells = STEADY_ITEMS - sent;
            send_cells(cells);
            sent += cells;
        end
    endtask

    initial
    begin : sink_pacing
        int stall_len;
        m_tready = 1'b0;
        forever
        begin
            @(posedge clk);
            if (hold_request)
            begin
                hold_request = 1'b0;
                m_tready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge clk);
                m_tready <= 1'b1;
            end
            else if (sink_stalls_on && $urandom_range(0, 5) == 0)
            begin
                stall_len = $urandom_range(1, 10);
                m_tready <= 1'b0;
                repeat (stall_len) @(posedge clk);
                m_tready <= 1'b1;
            end
            else
                m_tready <= 1'b1;
        end
    end

    always @(posedge clk)
    begin : check_results
        update_t want;
        if (rst_n && m_tvalid && m_tready)
        begin
            if (queued_updates.size() == 0)
            begin
                if (mismatch_count < 10)
                    $display("unexpected result: temp %0d last %0b", m_tdata, m_tlast);
                mismatch_count++;
            end
            else
            begin
                want = queued_updates.pop_front();
                if (m_tdata !== want.temp || m_tlast !== want.last)
                begin
                    if (mismatch_count < 10)
                        $display("mismatch: expected temp %0d last %0b, got temp %0d last %0b",
                                 want.temp, want.last, m_tdata, m_tlast);
                    mismatch_count++;
                end
            end
        end
    end

    always @(posedge clk)
    begin : watchdog
        if (rst_n)
        begin
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
                quiet_cycles = 0;
            else
                quiet_cycles++;
            if (quiet_cycles >= WATCHDOG_LIMIT)
            begin
                $display("TEST FAILED");
                $finish;
            end
        end
    end

    initial
    begin
        s_tvalid = 1'b0;
        s_tdata = '0;
        s_tuser = 1'b0;
        cfg_we = 1'b0;
        cfg_index = CFG_WIDTH;
        cfg_wdata = '0;
        rst_n = 1'b0;
        src_gaps_on = 1'b1;
        sink_stalls_on = 1'b1;
        hold_request = 1'b0;
        mismatch_count = 0;
        quiet_cycles = 0;
        foreach (upper_row[i])
        begin
            upper_row[i] = '0;
            lower_row[i] = '0;
        end
        foreach (window_cells[i])
            window_cells[i] = '0;
        col_pos = 0;
        row_pos = 0;
        grid_width = PW_BITS'(3);
        grid_height = ROW_BITS'(3);
        gain_k = GAIN_RESET;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;

        test_default_frame();
        test_rounding_and_heater();
        test_geometry_clamps();
        test_widest_rows();
        test_tallest_grid();
        test_output_holdoff();
        test_random_grids();
        test_steady_stream();

        s_tvalid <= 1'b0;
        while (queued_updates.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
        if (mismatch_count == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

endmodule

@@ heat_stencil_sweep.f @@
hdl/hss_pkg.sv
hdl/hss_line_store.sv
hdl/hss_cell.sv
hdl/hss_blend.sv
hdl/heat_stencil_sweep.sv
tb/heat_stencil_sweep_tb.sv
